@@ rtl/ect_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the encoder-set countdown timer.
// No dependencies; ect_band_step and the timer top level refer to it by scoped names.

package ect_pkg;

	localparam int CMD_W      = 2;
	localparam int DELTA_W    = 7;
	localparam int SEL_W      = 13;
	localparam int STEP_W     = 10;
	localparam int COUNT_W    = 20;
	localparam int MMSS_W     = 14;
	localparam int PCT_W      = 7;
	localparam int SECS_W     = 6;
	localparam int PCT_NUM_W  = 27;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// Command codes carried on the input tuser.
	localparam logic [CMD_W-1:0] CMD_ROTATE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PRESS  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SECONDS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SECONDS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_BAND_EDGE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_BAND_EDGE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REGULAR_STEP     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_STEP        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VERY_LONG_STEP   = 3'd6;

	localparam int SEL_MAX         = 8191;
	localparam int SECS_PER_MIN    = 60;
	localparam int PERCENT_FULL    = 100;
	localparam int MINS_SHOWN_MAX  = 99;
	localparam int MMSS_MIN_WEIGHT = 100;

	localparam logic [COUNT_W-1:0] COUNT_MAX     = 20'hFFFFF;
	localparam logic [MMSS_W-1:0]  MMSS_OVERFLOW = 14'd9959;

	localparam logic [SEL_W-1:0]  DEF_MIN_SECONDS      = 13'd0;
	localparam logic [SEL_W-1:0]  DEF_MAX_SECONDS      = 13'd5999;
	localparam logic [SEL_W-1:0]  DEF_FIRST_BAND_EDGE  = 13'd60;
	localparam logic [SEL_W-1:0]  DEF_SECOND_BAND_EDGE = 13'd600;
	localparam logic [STEP_W-1:0] DEF_REGULAR_STEP     = 10'd5;
	localparam logic [STEP_W-1:0] DEF_LONG_STEP        = 10'd30;
	localparam logic [STEP_W-1:0] DEF_VERY_LONG_STEP   = 10'd60;

	typedef struct packed {
		logic [SEL_W-1:0]  min_seconds;
		logic [SEL_W-1:0]  max_seconds;
		logic [SEL_W-1:0]  first_band_edge;
		logic [SEL_W-1:0]  second_band_edge;
		logic [STEP_W-1:0] regular_step;
		logic [STEP_W-1:0] long_step;
		logic [STEP_W-1:0] very_long_step;
	} cfg_t;

endpackage

`default_nettype wire

@@ rtl/ect_serial_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider that retires one quotient bit per cycle.
// Uses no package; instantiated by the timer top level.

module ect_serial_div #(
	parameter int NUM_W = 20,
	parameter int DEN_W = 13
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic [NUM_W-1:0]      quo,
	output logic [DEN_W-1:0]      rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] sh_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           fits;

	// The numerator shifts out at the top while quotient bits shift in at the bottom.
	assign trial = {rem_q, sh_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			sh_q  <= {sh_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quo  = sh_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

@@ rtl/ect_band_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Two-stage band step: picks the step of the current band, scales it by the
// detent delta, clamps at band edges and min/max seconds. Depends on ect_pkg.

module ect_band_step (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [ect_pkg::SEL_W-1:0]         sel,
	input  wire logic [ect_pkg::DELTA_W-1:0]       delta,
	input  wire ect_pkg::cfg_t                     cfg,
	output logic                                   done,
	output logic [ect_pkg::SEL_W-1:0]              next_sel
);

	localparam int SUM_W = 19;

	localparam logic [1:0] BAND_REGULAR   = 2'd0;
	localparam logic [1:0] BAND_LONG      = 2'd1;
	localparam logic [1:0] BAND_VERY_LONG = 2'd2;

	logic                           vld_s1;
	logic                           vld_s2;
	logic [ect_pkg::SEL_W-1:0]      sel_s1;
	logic [1:0]                     band_s1;
	logic signed [SUM_W-1:0]        prod_s1;
	logic signed [SUM_W-1:0]        e1m_s1;
	logic signed [SUM_W-1:0]        e2m_s1;
	logic [ect_pkg::SEL_W-1:0]      sel_s2;

	logic [1:0]                     band;
	logic [ect_pkg::STEP_W-1:0]     step;
	logic signed [SUM_W-1:0]        delta_x;
	logic signed [SUM_W-1:0]        step_x;
	logic signed [SUM_W-1:0]        lo_x;
	logic signed [SUM_W-1:0]        hi_x;
	logic signed [SUM_W-1:0]        e1_x;
	logic signed [SUM_W-1:0]        e2_x;
	logic signed [SUM_W-1:0]        sum;
	logic signed [SUM_W-1:0]        res;
	logic [ect_pkg::SEL_W-1:0]      res_sat;

	always_comb begin
		if (sel < cfg.first_band_edge) begin
			band = BAND_REGULAR;
			step = cfg.regular_step;
		end else if (sel < cfg.second_band_edge) begin
			band = BAND_LONG;
			step = cfg.long_step;
		end else begin
			band = BAND_VERY_LONG;
			step = cfg.very_long_step;
		end
	end

	assign delta_x = SUM_W'(signed'(delta));
	assign step_x  = SUM_W'(step);
	assign lo_x    = SUM_W'(cfg.min_seconds);
	assign hi_x    = SUM_W'(cfg.max_seconds);
	assign e1_x    = SUM_W'(cfg.first_band_edge);
	assign e2_x    = SUM_W'(cfg.second_band_edge);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sel_s1  <= sel;
			band_s1 <= band;
			prod_s1 <= delta_x * step_x;
			e1m_s1  <= e1_x - SUM_W'(cfg.regular_step);
			e2m_s1  <= e2_x - SUM_W'(cfg.long_step);
		end
		if (vld_s1) begin
			sel_s2 <= res_sat;
		end
	end

	assign sum = SUM_W'(sel_s1) + prod_s1;

	// A sum that leaves the long or very-long band downward lands one lower-band step below its edge.
	always_comb begin
		case (band_s1)
			BAND_REGULAR: begin
				if (sum >= e1_x) begin
					res = e1_x;
				end else if (sum < lo_x) begin
					res = lo_x;
				end else begin
					res = sum;
				end
			end
			BAND_LONG: begin
				if (sum >= e2_x) begin
					res = e2_x;
				end else if (sum < e1_x) begin
					res = e1m_s1;
				end else begin
					res = sum;
				end
			end
			default: begin
				if (sum > hi_x) begin
					res = hi_x;
				end else if (sum < e2_x) begin
					res = e2m_s1;
				end else begin
					res = sum;
				end
			end
		endcase
	end

	always_comb begin
		if (res[SUM_W-1]) begin
			res_sat = '0;
		end else if (|res[SUM_W-2:ect_pkg::SEL_W]) begin
			res_sat = '1;
		end else begin
			res_sat = res[ect_pkg::SEL_W-1:0];
		end
	end

	assign done     = vld_s2;
	assign next_sel = sel_s2;

endmodule

`default_nettype wire

@@ rtl/encoder_set_countdown_timer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Encoder-set countdown timer, top level. Depends on ect_pkg, ect_band_step, ect_serial_div.
// An accepted input passes the band step (rotation in idle), the load (press in idle) or the poll
// (any event while running); a tick or no-op in idle skips these. Then the two bit-serial passes
// of the time divider run, minutes then seconds; an expiring event skips them. One item is in work
// at a time; the next input transaction is taken from the cycle after the result is loaded.
// Reset clears mode, selection, counter and shown values and loads the register defaults.

module encoder_set_countdown_timer_core #(
	parameter int TICKS_PER_SECOND = 100
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ect_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ect_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [6:0] detent_delta, [7] zero fill
	input  wire logic [7:0]                        s_axis_tdata,
	// [1:0] cmd
	input  wire logic [ect_pkg::CMD_W-1:0]         s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// [0] display_changed, [14:1] display_mmss, [15] running, [22:16] percent_left,
	// [23] expired
	output logic [23:0]                            m_axis_tdata
);

	localparam int COUNT_W = ect_pkg::COUNT_W;
	localparam int TIME_DW = $clog2(ect_pkg::SECS_PER_MIN * TICKS_PER_SECOND + 1);
	localparam int DEN_W   = $clog2(ect_pkg::SEL_MAX * TICKS_PER_SECOND + 1);
	localparam int CMP_W   = (DEN_W > COUNT_W) ? DEN_W : COUNT_W;
	localparam int PNUM_W  = ect_pkg::PCT_NUM_W;

	localparam logic [TIME_DW-1:0] DIV_MIN_TICKS =
		TIME_DW'(ect_pkg::SECS_PER_MIN * TICKS_PER_SECOND);
	localparam logic [TIME_DW-1:0] DIV_MIN = TIME_DW'(ect_pkg::SECS_PER_MIN);
	localparam logic [TIME_DW-1:0] DIV_TPS = TIME_DW'(TICKS_PER_SECOND);
	localparam logic [TIME_DW-1:0] DIV_ONE = TIME_DW'(1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_BAND  = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_POLL  = 3'd3;
	localparam logic [2:0] ST_START = 3'd4;
	localparam logic [2:0] ST_DIV1  = 3'd5;
	localparam logic [2:0] ST_DIV2  = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	ect_pkg::cfg_t cfg_q;

	logic [2:0]                    state_q;
	logic                          running_q;
	logic [ect_pkg::SEL_W-1:0]     sel_q;
	logic [ect_pkg::SEL_W-1:0]     shown_sel_q;
	logic [COUNT_W-1:0]            count_q;
	logic [COUNT_W-1:0]            shown_count_q;
	logic                          show_count_q;
	logic                          pct_en_q;
	logic                          changed_q;
	logic                          expired_q;
	logic [DEN_W-1:0]              den_q;
	logic [COUNT_W-1:0]            mins_q;
	logic [ect_pkg::SECS_W-1:0]    secs_q;
	logic                          m_valid_q;
	logic [23:0]                   m_data_q;

	logic                          s_accept;
	logic [ect_pkg::CMD_W-1:0]     cmd;
	logic                          band_start;
	logic                          band_done;
	logic [ect_pkg::SEL_W-1:0]     band_sel;
	logic [DEN_W-1:0]              sel_ticks;
	logic [COUNT_W-1:0]            load_sat;
	logic                          out_load;

	logic                          tdiv_start;
	logic [COUNT_W-1:0]            tdiv_num;
	logic [TIME_DW-1:0]            tdiv_den;
	logic                          tdiv_busy;
	logic [COUNT_W-1:0]            tdiv_quo;
	logic [TIME_DW-1:0]            tdiv_rem;

	logic                          pdiv_start;
	logic [PNUM_W-1:0]             pdiv_num;
	logic                          pdiv_busy;
	logic [PNUM_W-1:0]             pdiv_quo;
	logic [DEN_W-1:0]              pdiv_rem;

	logic [ect_pkg::MMSS_W-1:0]    mmss;
	logic [ect_pkg::PCT_W-1:0]     pct;

	assign cmd           = s_axis_tuser;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign band_start    = s_accept && !running_q && (cmd == ect_pkg::CMD_ROTATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_seconds      <= ect_pkg::DEF_MIN_SECONDS;
			cfg_q.max_seconds      <= ect_pkg::DEF_MAX_SECONDS;
			cfg_q.first_band_edge  <= ect_pkg::DEF_FIRST_BAND_EDGE;
			cfg_q.second_band_edge <= ect_pkg::DEF_SECOND_BAND_EDGE;
			cfg_q.regular_step     <= ect_pkg::DEF_REGULAR_STEP;
			cfg_q.long_step        <= ect_pkg::DEF_LONG_STEP;
			cfg_q.very_long_step   <= ect_pkg::DEF_VERY_LONG_STEP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ect_pkg::REG_MIN_SECONDS:      cfg_q.min_seconds      <= cfg_data;
				ect_pkg::REG_MAX_SECONDS:      cfg_q.max_seconds      <= cfg_data;
				ect_pkg::REG_FIRST_BAND_EDGE:  cfg_q.first_band_edge  <= cfg_data;
				ect_pkg::REG_SECOND_BAND_EDGE: cfg_q.second_band_edge <= cfg_data;
				ect_pkg::REG_REGULAR_STEP:
					cfg_q.regular_step   <= cfg_data[ect_pkg::STEP_W-1:0];
				ect_pkg::REG_LONG_STEP:
					cfg_q.long_step      <= cfg_data[ect_pkg::STEP_W-1:0];
				ect_pkg::REG_VERY_LONG_STEP:
					cfg_q.very_long_step <= cfg_data[ect_pkg::STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ect_band_step u_band (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (band_start),
		.sel      (sel_q),
		.delta    (s_axis_tdata[ect_pkg::DELTA_W-1:0]),
		.cfg      (cfg_q),
		.done     (band_done),
		.next_sel (band_sel)
	);

	assign sel_ticks = DEN_W'(sel_q) * DEN_W'(TICKS_PER_SECOND);
	assign load_sat  = (CMP_W'(sel_ticks) > CMP_W'(ect_pkg::COUNT_MAX)) ?
		ect_pkg::COUNT_MAX : COUNT_W'(sel_ticks);

	// The time divider runs twice: whole minutes first, then seconds from the remainder.
	assign tdiv_start = (state_q == ST_START) || ((state_q == ST_DIV1) && !tdiv_busy);

	always_comb begin
		if (state_q == ST_DIV1) begin
			tdiv_num = COUNT_W'(tdiv_rem);
			tdiv_den = show_count_q ? DIV_TPS : DIV_ONE;
		end else begin
			tdiv_num = show_count_q ? count_q : COUNT_W'(sel_q);
			tdiv_den = show_count_q ? DIV_MIN_TICKS : DIV_MIN;
		end
	end

	assign pdiv_start = (state_q == ST_START);
	assign pdiv_num   = PNUM_W'(count_q) * PNUM_W'(ect_pkg::PERCENT_FULL);

	ect_serial_div #(
		.NUM_W (COUNT_W),
		.DEN_W (TIME_DW)
	) u_time_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (tdiv_start),
		.num    (tdiv_num),
		.den    (tdiv_den),
		.busy   (tdiv_busy),
		.quo    (tdiv_quo),
		.rem    (tdiv_rem)
	);

	ect_serial_div #(
		.NUM_W (PNUM_W),
		.DEN_W (DEN_W)
	) u_pct_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pdiv_start),
		.num    (pdiv_num),
		.den    (den_q),
		.busy   (pdiv_busy),
		.quo    (pdiv_quo),
		.rem    (pdiv_rem)
	);

	always_comb begin
		if (mins_q > COUNT_W'(ect_pkg::MINS_SHOWN_MAX)) begin
			mmss = ect_pkg::MMSS_OVERFLOW;
		end else begin
			mmss = ect_pkg::MMSS_W'(ect_pkg::MMSS_W'(mins_q[6:0]) *
				ect_pkg::MMSS_W'(ect_pkg::MMSS_MIN_WEIGHT)) + ect_pkg::MMSS_W'(secs_q);
		end
	end

	// A zero denominator leaves the percentage at zero; the remainder is not needed.
	always_comb begin
		if (!pct_en_q || (den_q == '0) || (pdiv_rem == '1 && 1'b0)) begin
			pct = '0;
		end else if (pdiv_quo > PNUM_W'(ect_pkg::PERCENT_FULL)) begin
			pct = ect_pkg::PCT_W'(ect_pkg::PERCENT_FULL);
		end else begin
			pct = pdiv_quo[ect_pkg::PCT_W-1:0];
		end
	end

	assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			running_q     <= 1'b0;
			sel_q         <= '0;
			shown_sel_q   <= '0;
			count_q       <= '0;
			shown_count_q <= '0;
			show_count_q  <= 1'b0;
			pct_en_q      <= 1'b0;
			changed_q     <= 1'b0;
			expired_q     <= 1'b0;
			m_valid_q     <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						changed_q    <= 1'b0;
						expired_q    <= 1'b0;
						show_count_q <= 1'b0;
						pct_en_q     <= 1'b0;
						if (running_q) begin
							if ((cmd == ect_pkg::CMD_TICK) && (count_q != '0)) begin
								count_q <= count_q - COUNT_W'(1);
							end
							state_q <= ST_POLL;
						end else if (cmd == ect_pkg::CMD_ROTATE) begin
							state_q <= ST_BAND;
						end else if (cmd == ect_pkg::CMD_PRESS) begin
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_START;
						end
					end
				end
				ST_BAND: begin
					if (band_done) begin
						sel_q <= band_sel;
						if (band_sel != shown_sel_q) begin
							shown_sel_q <= band_sel;
							changed_q   <= 1'b1;
						end
						state_q <= ST_START;
					end
				end
				ST_LOAD: begin
					count_q       <= load_sat;
					shown_count_q <= '0;
					running_q     <= 1'b1;
					pct_en_q      <= 1'b1;
					state_q       <= ST_START;
				end
				ST_POLL: begin
					if (count_q == '0) begin
						sel_q       <= '0;
						shown_sel_q <= '0;
						running_q   <= 1'b0;
						changed_q   <= 1'b1;
						expired_q   <= 1'b1;
						state_q     <= ST_DONE;
					end else begin
						if (count_q != shown_count_q) begin
							shown_count_q <= count_q;
							changed_q     <= 1'b1;
						end
						show_count_q <= 1'b1;
						pct_en_q     <= 1'b1;
						state_q      <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_DIV1;
				end
				ST_DIV1: begin
					if (!tdiv_busy) begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (!tdiv_busy && !pdiv_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: divisor for the percentage, the split time and the result.
	always_ff @(posedge clk) begin
		if ((state_q == ST_LOAD) || (state_q == ST_POLL)) begin
			den_q <= sel_ticks;
		end
		if ((state_q == ST_POLL) && (count_q == '0)) begin
			mins_q <= '0;
			secs_q <= '0;
		end
		if ((state_q == ST_DIV1) && !tdiv_busy) begin
			mins_q <= tdiv_quo;
		end
		if ((state_q == ST_DIV2) && !tdiv_busy && !pdiv_busy) begin
			secs_q <= tdiv_quo[ect_pkg::SECS_W-1:0];
		end
		if (out_load) begin
			m_data_q <= {expired_q, pct, running_q, mmss, changed_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire
